>>> sv/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types and codes for the sorted record table: beat layouts, the
// stored record and the command that the controller hands to every cell.
// ----------------------------------------------------------------------------
package srt_pkg;

  // Operation codes of an input beat
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_DUMP   = 2'd3;

  // Result codes of an output beat
  localparam logic [1:0] RC_OK       = 2'd0;
  localparam logic [1:0] RC_NOTFOUND = 2'd1;
  localparam logic [1:0] RC_FULL     = 2'd2;
  localparam logic [1:0] RC_EMPTY    = 2'd3;

  // One stored record (36 bits)
  typedef struct packed {
    logic [15:0] id;
    logic [2:0]  kind;
    logic [7:0]  batt;
    logic        stat;
    logic [7:0]  key;
  } rec_t;

  // Input beat
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] item_id;
    logic [2:0]  vehicle_kind;
    logic [7:0]  battery;
    logic        vehicle_status;
    logic [7:0]  sort_key;
  } in_t;

  // Output beat
  typedef struct packed {
    logic [1:0]  result_code;
    logic [15:0] out_id;
    logic [2:0]  out_kind;
    logic [7:0]  out_battery;
    logic        out_status;
    logic [7:0]  out_key;
    logic        last;
  } out_t;

  // Command broadcast to the cell row
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROTATE,
    CELL_DROP
  } cell_op_t;

endpackage

>>> sv/srt_cell.sv
// ----------------------------------------------------------------------------
// srt_cell
// One slot of the ordered record row. Holds a record and its valid bit and
// moves data to or from its neighbors on insert, rotate and drop.
// ----------------------------------------------------------------------------
module srt_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_cell_i,   // first slot: strict key compare
  input  srt_pkg::cell_op_t cmd_i,
  input  srt_pkg::rec_t    new_rec_i,
  input  srt_pkg::rec_t    head_rec_i,
  input  logic             prev_ge_i,
  input  srt_pkg::rec_t    prev_rec_i,
  input  logic             prev_valid_i,
  input  srt_pkg::rec_t    next_rec_i,
  input  logic             next_valid_i,
  output logic             ge_o,
  output srt_pkg::rec_t    rec_o,
  output logic             valid_o
);
  import srt_pkg::*;

  rec_t rec_r, rec_nxt;
  logic valid_r, valid_nxt;

  // Insert position lies at or before this slot
  always_comb begin
    if (head_cell_i) begin
      ge_o = !valid_r || (rec_r.key < new_rec_i.key);
    end else begin
      ge_o = !valid_r || (rec_r.key <= new_rec_i.key);
    end
  end

  // Next slot contents
  always_comb begin
    rec_nxt   = rec_r;
    valid_nxt = valid_r;
    unique case (cmd_i)
      CELL_HOLD: begin
      end
      CELL_INSERT: begin
        if (ge_o) begin
          if (prev_ge_i) begin
            rec_nxt   = prev_rec_i;
            valid_nxt = prev_valid_i;
          end else begin
            rec_nxt   = new_rec_i;
            valid_nxt = 1'b1;
          end
        end
      end
      CELL_ROTATE: begin
        // shift toward the head; the tail slot picks up the old head
        if (next_valid_i) begin
          rec_nxt = next_rec_i;
        end else if (valid_r) begin
          rec_nxt = head_rec_i;
        end
      end
      CELL_DROP: begin
        rec_nxt   = next_rec_i;
        valid_nxt = next_valid_i;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec_o   = rec_r;
  assign valid_o = valid_r;

endmodule

>>> sv/sorted_record_table.sv
// Insert, and any op on an empty table, answers from the exec state. Remove
// and lookup scan the row and answer from the done state; dump emits one
// beat per step, one beat per cycle while the output is not stalled. Each
// step moves the whole cell row by one slot, so the record count sets the scan length.
// Throughput: one op in flight at a time. Reset empties the table at once
// (valid bits clear); no clearing pass.
// ----------------------------------------------------------------------------
// sorted_record_table
// Bounded table of records in descending key order, built as a row of
// cells. Lookups, removes and dumps rotate the row once around.
// ----------------------------------------------------------------------------
module sorted_record_table #(
  parameter int CAPACITY = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  srt_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output srt_pkg::out_t  out_data
);
  import srt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [1:0]       op_r, op_nxt;
  rec_t             req_r, req_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] steps_r, steps_nxt;
  logic             found_r, found_nxt;
  rec_t             hit_r, hit_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_r, out_nxt;

  cell_op_t         cell_cmd;
  rec_t             rec_w   [CAPACITY];
  logic             valid_w [CAPACITY];
  logic             ge_w    [CAPACITY];
  logic [CAPACITY-1:0] valid_vec;
  rec_t             head_rec;
  logic             out_free;
  logic             full;

  function automatic out_t pack_out(logic [1:0] code, rec_t r, logic lst);
    out_t o;
    o.result_code = code;
    o.out_id      = r.id;
    o.out_kind    = r.kind;
    o.out_battery = r.batt;
    o.out_status  = r.stat;
    o.out_key     = r.key;
    o.last        = lst;
    return o;
  endfunction

  // Cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    rec_t p_rec, n_rec;
    logic p_ge, p_valid, n_valid;
    if (i == 0) begin : g_first
      assign p_rec   = '0;
      assign p_ge    = 1'b0;
      assign p_valid = 1'b0;
    end else begin : g_mid
      assign p_rec   = rec_w[i-1];
      assign p_ge    = ge_w[i-1];
      assign p_valid = valid_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign n_rec   = '0;
      assign n_valid = 1'b0;
    end else begin : g_body
      assign n_rec   = rec_w[i+1];
      assign n_valid = valid_w[i+1];
    end

    srt_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .head_cell_i  (i == 0),
      .cmd_i        (cell_cmd),
      .new_rec_i    (req_r),
      .head_rec_i   (head_rec),
      .prev_ge_i    (p_ge),
      .prev_rec_i   (p_rec),
      .prev_valid_i (p_valid),
      .next_rec_i   (n_rec),
      .next_valid_i (n_valid),
      .ge_o         (ge_w[i]),
      .rec_o        (rec_w[i]),
      .valid_o      (valid_w[i])
    );
    assign valid_vec[i] = valid_w[i];
  end

  assign head_rec = rec_w[0];
  assign out_free = !out_valid_r || !out_stall;
  assign full     = (count_r == CNT_W'(CAPACITY));

  // Control sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    req_nxt       = req_r;
    count_nxt     = count_r;
    steps_nxt     = steps_r;
    found_nxt     = found_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    cell_cmd      = CELL_HOLD;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt       = in_data.op;
          req_nxt.id   = in_data.item_id;
          req_nxt.kind = in_data.vehicle_kind;
          req_nxt.batt = in_data.battery;
          req_nxt.stat = in_data.vehicle_status;
          req_nxt.key  = in_data.sort_key;
          state_nxt    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (op_r)
          OP_INSERT: begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_nxt = pack_out(RC_FULL, '0, 1'b1);
              end else begin
                cell_cmd  = CELL_INSERT;
                count_nxt = count_r + 1'b1;
                out_nxt   = pack_out(RC_OK, req_r, 1'b1);
              end
              state_nxt = ST_IDLE;
            end
          end
          OP_REMOVE, OP_LOOKUP: begin
            if (count_r == '0) begin
              if (out_free) begin
                out_valid_nxt = 1'b1;
                out_nxt       = pack_out(RC_NOTFOUND, '0, 1'b1);
                state_nxt     = ST_IDLE;
              end
            end else begin
              steps_nxt = count_r;
              found_nxt = 1'b0;
              state_nxt = ST_SCAN;
            end
          end
          OP_DUMP: begin
            if (count_r == '0) begin
              if (out_free) begin
                out_valid_nxt = 1'b1;
                out_nxt       = pack_out(RC_EMPTY, '0, 1'b1);
                state_nxt     = ST_IDLE;
              end
            end else begin
              steps_nxt = count_r;
              state_nxt = ST_SCAN;
            end
          end
        endcase
      end
      ST_SCAN: begin
        if (op_r == OP_DUMP) begin
          // one beat per step, head of the row
          if (out_free) begin
            cell_cmd      = CELL_ROTATE;
            out_valid_nxt = 1'b1;
            out_nxt       = pack_out(RC_OK, head_rec, steps_r == CNT_W'(1));
            steps_nxt     = steps_r - 1'b1;
            if (steps_r == CNT_W'(1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end else begin
          cell_cmd = CELL_ROTATE;
          if (!found_r && (head_rec.id == req_r.id)) begin
            found_nxt = 1'b1;
            hit_nxt   = head_rec;
            if (op_r == OP_REMOVE) begin
              cell_cmd  = CELL_DROP;
              count_nxt = count_r - 1'b1;
            end
          end
          steps_nxt = steps_r - 1'b1;
          if (steps_r == CNT_W'(1)) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (found_r) begin
            out_nxt = pack_out(RC_OK, hit_r, 1'b1);
          end else begin
            out_nxt = pack_out(RC_NOTFOUND, '0, 1'b1);
          end
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      steps_r     <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      steps_r     <= steps_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r  <= op_nxt;
    req_r <= req_nxt;
    hit_r <= hit_nxt;
    out_r <= out_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("record count above capacity");

  a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + CAPACITY'(1))) == '0)
    else $error("valid slots not packed toward the head");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> $countones(valid_vec) == int'(count_r))
    else $error("record count disagrees with valid slots");

  a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
    cell_cmd == CELL_INSERT |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow the table");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sorted_record_table. A scoreboard keeps its own
// copy of the ordered table, works out the result beats of every accepted
// command and checks each output beat against the oldest one pending.
// Stimulus is a directed opening followed by random fill/drain cycles run
// under four sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module testbench;
  import srt_pkg::*;

  // Shadow table plus the queue of result beats still owed by the block
  class table_tracker;
    rec_t        rows[$];
    out_t        expected_beats[$];
    int unsigned depth;
    int unsigned errors;

    function new(int unsigned cap);
      depth  = cap;
      errors = 0;
    endfunction

    function out_t make_beat(logic [1:0] code, rec_t r, logic lst);
      out_t o;
      o.result_code = code;
      o.out_id      = r.id;
      o.out_kind    = r.kind;
      o.out_battery = r.batt;
      o.out_status  = r.stat;
      o.out_key     = r.key;
      o.last        = lst;
      return o;
    endfunction

    function string beat_text(out_t o);
      return $sformatf("code=%0d id=%h kind=%0d batt=%0d stat=%0d key=%0d last=%0d",
                       o.result_code, o.out_id, o.out_kind, o.out_battery,
                       o.out_status, o.out_key, o.last);
    endfunction

    // Apply one accepted command to the shadow table, queue its result beats
    function void apply_command(in_t b);
      rec_t r;
      rec_t blank;
      int   pos;
      int   hit;
      blank = '0;
      case (b.op)
        OP_INSERT: begin
          if (rows.size() >= depth) begin
            expected_beats.push_back(make_beat(RC_FULL, blank, 1'b1));
          end else begin
            r.id   = b.item_id;
            r.kind = b.vehicle_kind;
            r.batt = b.battery;
            r.stat = b.vehicle_status;
            r.key  = b.sort_key;
            // new head only on a strictly greater key; else walk past larger keys
            if (rows.size() == 0 || rows[0].key < r.key) begin
              pos = 0;
            end else begin
              pos = 1;
              while (pos < rows.size() && rows[pos].key > r.key) pos++;
            end
            rows.insert(pos, r);
            expected_beats.push_back(make_beat(RC_OK, r, 1'b1));
          end
        end
        OP_REMOVE, OP_LOOKUP: begin
          hit = -1;
          foreach (rows[i]) begin
            if (hit < 0 && rows[i].id == b.item_id) hit = i;
          end
          if (hit < 0) begin
            expected_beats.push_back(make_beat(RC_NOTFOUND, blank, 1'b1));
          end else begin
            r = rows[hit];
            if (b.op == OP_REMOVE) rows.delete(hit);
            expected_beats.push_back(make_beat(RC_OK, r, 1'b1));
          end
        end
        OP_DUMP: begin
          if (rows.size() == 0) begin
            expected_beats.push_back(make_beat(RC_EMPTY, blank, 1'b1));
          end else begin
            foreach (rows[i]) begin
              expected_beats.push_back(make_beat(RC_OK, rows[i], i == rows.size() - 1));
            end
          end
        end
        default: ;
      endcase
    endfunction

    // Check one accepted output beat against the oldest pending one
    function void compare_beat(out_t got);
      out_t want;
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: %s", beat_text(got));
        return;
      end
      want = expected_beats.pop_front();
      if (got.result_code !== want.result_code || got.out_id !== want.out_id ||
          got.out_kind !== want.out_kind || got.out_battery !== want.out_battery ||
          got.out_status !== want.out_status || got.out_key !== want.out_key ||
          got.last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $display("result mismatch at %0t", $realtime);
          $display("  expected %s", beat_text(want));
          $display("  actual   %s", beat_text(got));
        end
      end
    endfunction
  endclass

  localparam int CAPACITY     = 32;
  localparam int RANDOM_ITEMS = 440;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  table_tracker tracker;

  sorted_record_table #(.CAPACITY(CAPACITY)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Output monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.compare_beat(out_data);
  end

  function automatic in_t make_cmd(logic [1:0] op, logic [15:0] id, logic [2:0] kind,
                                   logic [7:0] batt, logic stat, logic [7:0] key);
    in_t b;
    b.op             = op;
    b.item_id        = id;
    b.vehicle_kind   = kind;
    b.battery        = batt;
    b.vehicle_status = stat;
    b.sort_key       = key;
    return b;
  endfunction

  // Random command; growing mode favors inserts, otherwise removes/lookups
  function automatic in_t random_cmd(input bit growing);
    in_t         b;
    int unsigned roll;
    int unsigned n;
    n = tracker.rows.size();
    b = make_cmd(OP_INSERT, 16'($urandom_range(65535)), 3'($urandom_range(7)),
                 8'($urandom_range(255)), 1'($urandom_range(1)),
                 8'($urandom_range(255)));
    roll = $urandom_range(99);
    if (growing) begin
      b.op = (roll < 78) ? OP_INSERT : (roll < 86) ? OP_LOOKUP :
             (roll < 93) ? OP_REMOVE : OP_DUMP;
    end else begin
      b.op = (roll < 12) ? OP_INSERT : (roll < 62) ? OP_REMOVE :
             (roll < 88) ? OP_LOOKUP : OP_DUMP;
    end
    // reuse stored ids and keys so matches, duplicates and key ties happen
    if (n != 0 && $urandom_range(99) < ((b.op == OP_INSERT) ? 25 : 80))
      b.item_id = tracker.rows[$urandom_range(n - 1)].id;
    if (b.op == OP_INSERT && n != 0 && $urandom_range(99) < 25)
      b.sort_key = tracker.rows[$urandom_range(n - 1)].key;
    return b;
  endfunction

  // Present one beat and hold it until accepted; maybe idle afterwards
  task automatic send_beat(input in_t b);
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.apply_command(b);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
  endtask

  // Hold off the sender until every pending result beat has come out
  task automatic drain_table;
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_beats.size() != 0) @(posedge clk);
  endtask

  // Run limit
  initial begin
    #3_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    in_t         opening[$];
    bit          growing;
    int unsigned idle_mix[4];
    int unsigned stall_mix[4];
    tracker = new(CAPACITY);
    idle_mix  = '{0, 56, 0, 35};
    stall_mix = '{0, 0, 56, 35};

    // Directed opening: empty table, extremes, ties, duplicates, misses
    opening.push_back(make_cmd(OP_DUMP,   16'h0000, 3'd0, 8'h00, 1'b0, 8'h00));
    opening.push_back(make_cmd(OP_REMOVE, 16'h0000, 3'd7, 8'hFF, 1'b1, 8'hFF));
    opening.push_back(make_cmd(OP_LOOKUP, 16'hFFFF, 3'd0, 8'h00, 1'b0, 8'h00));
    opening.push_back(make_cmd(OP_INSERT, 16'h0000, 3'd0, 8'h00, 1'b0, 8'h00));
    opening.push_back(make_cmd(OP_INSERT, 16'hFFFF, 3'd7, 8'hFF, 1'b1, 8'hFF));
    opening.push_back(make_cmd(OP_INSERT, 16'h1234, 3'd5, 8'h5A, 1'b1, 8'h80));
    opening.push_back(make_cmd(OP_INSERT, 16'h1234, 3'd6, 8'hA5, 1'b0, 8'h80));
    opening.push_back(make_cmd(OP_INSERT, 16'h00FF, 3'd4, 8'h01, 1'b1, 8'hFF));
    opening.push_back(make_cmd(OP_INSERT, 16'hFF00, 3'd1, 8'hFE, 1'b0, 8'h00));
    opening.push_back(make_cmd(OP_INSERT, 16'h5555, 3'd2, 8'h33, 1'b1, 8'h7F));
    opening.push_back(make_cmd(OP_LOOKUP, 16'h1234, 3'd3, 8'hCC, 1'b1, 8'h11));
    opening.push_back(make_cmd(OP_LOOKUP, 16'hAAAA, 3'd0, 8'h00, 1'b0, 8'h00));
    opening.push_back(make_cmd(OP_DUMP,   16'hFFFF, 3'd7, 8'hFF, 1'b1, 8'hFF));
    opening.push_back(make_cmd(OP_REMOVE, 16'h1234, 3'd0, 8'h00, 1'b0, 8'h00));
    opening.push_back(make_cmd(OP_LOOKUP, 16'h1234, 3'd0, 8'h00, 1'b0, 8'h00));
    opening.push_back(make_cmd(OP_REMOVE, 16'hFFFF, 3'd0, 8'h00, 1'b0, 8'h00));
    opening.push_back(make_cmd(OP_REMOVE, 16'hFF00, 3'd0, 8'h00, 1'b0, 8'h00));
    opening.push_back(make_cmd(OP_REMOVE, 16'hAAAA, 3'd0, 8'h00, 1'b0, 8'h00));
    opening.push_back(make_cmd(OP_DUMP,   16'h0000, 3'd0, 8'h00, 1'b0, 8'h00));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening[i]) send_beat(opening[i]);
    drain_table;

    // Random part: fill to full, overflow a few times, drain back to empty
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_mix[ph];
      stall_pct = stall_mix[ph];
      growing   = 1'b1;
      for (int k = 0; k < RANDOM_ITEMS / 4; k++) begin
        if (tracker.rows.size() == CAPACITY && $urandom_range(3) == 0) growing = 1'b0;
        if (tracker.rows.size() == 0) growing = 1'b1;
        send_beat(random_cmd(growing));
        if ($urandom_range(99) == 0) drain_table;
      end
      drain_table;
    end

    // Let any stray beats show up
    stall_pct = 0;
    repeat (40) @(posedge clk);

    if (tracker.errors == 0 && tracker.expected_beats.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
